[design/triangle_height_rasterizer_macros.svh]
// ----------------------------------------------------------------------------
// Triangle height rasterizer assertion macros
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_HEIGHT_RASTERIZER_MACROS_SVH
`define TRIANGLE_HEIGHT_RASTERIZER_MACROS_SVH

`ifndef SYNTHESIS
`define THR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("thr assertion failed");
`define THR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("thr assertion failed");
`else
`define THR_ASSERT_IMP(lbl, ante, cons)
`define THR_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[design/thr_pkg.sv]
// ----------------------------------------------------------------------------
// thr_pkg
// Shared types and constants of the triangle height rasterizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package thr_pkg;

	localparam int CW   = 12;
	localparam int ZW   = 16;
	localparam int DW   = 13;
	localparam int ZDW  = 17;
	localparam int NW   = 48;
	localparam int EW   = 32;
	localparam int RW   = 27;
	localparam int PXW  = 9;
	localparam int CNTW = 17;
	localparam int KW   = 2;
	localparam int CFG_IW = 2;
	localparam int CFG_DW = 9;

	localparam logic [KW-1:0] KIND_DRAW  = 2'd0;
	localparam logic [KW-1:0] KIND_READ  = 2'd1;
	localparam logic [KW-1:0] KIND_CLEAR = 2'd2;

	localparam logic [CFG_IW-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IW-1:0] REG_HEIGHT = 2'd1;

	typedef struct packed {
		logic [KW-1:0]        kind;
		logic signed [CW-1:0] ax;
		logic signed [CW-1:0] ay;
		logic signed [ZW-1:0] az;
		logic signed [CW-1:0] bx;
		logic signed [CW-1:0] by_row;
		logic signed [ZW-1:0] bz;
		logic signed [CW-1:0] cx;
		logic signed [CW-1:0] cy;
		logic signed [ZW-1:0] cz;
		logic [7:0]           read_col;
		logic [7:0]           read_row;
	} item_t;

	typedef struct packed {
		logic [7:0]      read_value;
		logic [CNTW-1:0] pixels_written;
		logic            read_outside;
	} result_t;

	typedef struct packed {
		logic                 empty;
		logic [PXW-1:0]       xs;
		logic [PXW-1:0]       xe;
		logic [PXW-1:0]       ys;
		logic [PXW-1:0]       ye;
		logic [2:0][EW-1:0]   e0;
		logic [2:0][DW-1:0]   edx;
		logic [2:0][DW-1:0]   edy;
		logic [NW-1:0]        num0;
		logic [NW-1:0]        ndx;
		logic [NW-1:0]        ndy;
		logic [RW-1:0]        nzp;
		logic [2:0][7:0]      q;
		logic [2:0][RW-1:0]   r;
	} scan_cfg_t;

endpackage

[design/thr_div.sv]
// ----------------------------------------------------------------------------
// thr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module thr_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [thr_pkg::NW-1:0]  dividend,
	input  logic [thr_pkg::RW-1:0]  divisor,
	output logic                    done,
	output logic [7:0]              quo_lo,
	output logic [thr_pkg::RW-1:0]  rem
);
	import thr_pkg::*;

	localparam int CNT_W = $clog2(NW + 1);

	logic [NW-1:0]    quo_q;
	logic [RW-1:0]    rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [RW:0]      rem_sh;
	logic [RW:0]      diff;
	logic             ge;

	assign rem_sh = {rem_q, quo_q[NW-1]};
	assign ge     = rem_sh >= {1'b0, divisor};
	assign diff   = rem_sh - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_W'(NW - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(NW - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], ge};
			rem_q <= ge ? diff[RW-1:0] : rem_sh[RW-1:0];
		end
	end

	assign done   = done_q;
	assign quo_lo = quo_q[7:0];
	assign rem    = rem_q;

endmodule

[design/thr_setup.sv]
// ----------------------------------------------------------------------------
// thr_setup
// Triangle setup: edge functions, clipped box, plane normal, start height,
// and the quotient/remainder pairs of the incremental plane division.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module thr_setup (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  thr_pkg::item_t           item,
	input  logic [thr_pkg::PXW-1:0]  w_used,
	input  logic [thr_pkg::PXW-1:0]  h_used,
	output logic                     done,
	output thr_pkg::scan_cfg_t       cfg
);
	import thr_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PIPE = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [2:0] PIPE_LAT = 3'd6;

	localparam int PW   = 30;
	localparam int NZPW = 26;
	localparam int NZW  = 27;
	localparam int NXW  = 31;
	localparam int EPW  = 26;
	localparam int OFW  = 14;

	logic [1:0] state_q;
	logic [2:0] cnt_q;
	logic [1:0] sel_q;

	logic signed [CW-1:0] px [3];
	logic signed [CW-1:0] py [3];
	logic signed [CW-1:0] qx [3];
	logic signed [CW-1:0] qy [3];
	logic signed [DW-1:0] dx_c [3];
	logic signed [DW-1:0] dy_c [3];
	logic signed [CW-1:0] xmin, xmax, ymin, ymax;
	logic signed [DW-1:0] xs_c, xe_c, ys_c, ye_c, wl, hl;

	// stage 1
	logic signed [DW-1:0]  ux_s1, uy_s1, vx_s1, vy_s1;
	logic signed [ZDW-1:0] uz_s1, vz_s1;
	logic signed [DW-1:0]  dx_s1 [3];
	logic signed [DW-1:0]  dy_s1 [3];
	logic                  bias_s1 [3];
	logic signed [DW-1:0]  xs_s1, ys_s1;
	logic [PXW-1:0]        xe_s1, ye_s1;
	logic                  empty_s1;
	logic signed [OFW-1:0] xoff_s1, yoff_s1;
	// stage 2
	logic signed [PW-1:0]  nxa_s2, nxb_s2, nya_s2, nyb_s2;
	logic signed [NZPW-1:0] nza_s2, nzb_s2;
	logic signed [EPW-1:0] dypx_s2 [3];
	logic signed [EPW-1:0] dxpy_s2 [3];
	logic signed [EPW-1:0] dxys_s2 [3];
	logic signed [EPW-1:0] dyxs_s2 [3];
	// stage 3
	logic signed [NXW-1:0] nx_s3, ny_s3;
	logic signed [NZW-1:0] nz_s3;
	logic signed [EW-1:0]  e0_s3 [3];
	// stage 4
	logic signed [NW-1:0]  pz_s4, pnx_s4, pny_s4;
	// stage 5
	logic signed [NW-1:0]  num_s5;
	// stage 6
	logic signed [NW-1:0]  num_s6, ndx_s6, ndy_s6;
	logic [RW-1:0]         nzp_s6;
	logic                  empty_s6;

	logic [7:0]    q_q [3];
	logic [RW-1:0] r_q [3];

	logic          div_start;
	logic          div_done;
	logic [7:0]    div_quo;
	logic [RW-1:0] div_rem;
	logic [1:0]    dsel;
	logic signed [NW-1:0] dval;
	logic [NW-1:0] dabs;
	logic signed [NW-1:0] cval;
	logic          cneg;
	logic [7:0]    q_fix;
	logic [RW-1:0] r_fix;

	assign px[0] = item.ax;     assign py[0] = item.ay;
	assign qx[0] = item.bx;     assign qy[0] = item.by_row;
	assign px[1] = item.bx;     assign py[1] = item.by_row;
	assign qx[1] = item.cx;     assign qy[1] = item.cy;
	assign px[2] = item.cx;     assign py[2] = item.cy;
	assign qx[2] = item.ax;     assign qy[2] = item.ay;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dx_c[i] = DW'(px[i]) - DW'(qx[i]);
			dy_c[i] = DW'(py[i]) - DW'(qy[i]);
		end
		xmin = (item.ax < item.bx) ? item.ax : item.bx;
		xmin = (xmin < item.cx) ? xmin : item.cx;
		xmax = (item.ax > item.bx) ? item.ax : item.bx;
		xmax = (xmax > item.cx) ? xmax : item.cx;
		ymin = (item.ay < item.by_row) ? item.ay : item.by_row;
		ymin = (ymin < item.cy) ? ymin : item.cy;
		ymax = (item.ay > item.by_row) ? item.ay : item.by_row;
		ymax = (ymax > item.cy) ? ymax : item.cy;
		wl   = $signed({4'b0, w_used});
		hl   = $signed({4'b0, h_used});
		xs_c = (xmin < 0) ? '0 : DW'(xmin);
		ys_c = (ymin < 0) ? '0 : DW'(ymin);
		xe_c = (DW'(xmax) > wl) ? wl : DW'(xmax);
		ye_c = (DW'(ymax) > hl) ? hl : DW'(ymax);
	end

	always_ff @(posedge clk) begin
		ux_s1 <= DW'(item.bx) - DW'(item.ax);
		uy_s1 <= DW'(item.by_row) - DW'(item.ay);
		uz_s1 <= ZDW'(item.bz) - ZDW'(item.az);
		vx_s1 <= DW'(item.cx) - DW'(item.ax);
		vy_s1 <= DW'(item.cy) - DW'(item.ay);
		vz_s1 <= ZDW'(item.cz) - ZDW'(item.az);
		for (int i = 0; i < 3; i++) begin
			dx_s1[i]   <= dx_c[i];
			dy_s1[i]   <= dy_c[i];
			bias_s1[i] <= (dy_c[i] < 0) || ((dy_c[i] == 0) && (dx_c[i] > 0));
		end
		xs_s1    <= xs_c;
		ys_s1    <= ys_c;
		xe_s1    <= xe_c[PXW-1:0];
		ye_s1    <= ye_c[PXW-1:0];
		empty_s1 <= (xs_c >= xe_c) || (ys_c >= ye_c);
		xoff_s1  <= OFW'(xs_c) - OFW'(item.ax);
		yoff_s1  <= OFW'(ys_c) - OFW'(item.ay);

		nxa_s2 <= PW'(uy_s1) * PW'(vz_s1);
		nxb_s2 <= PW'(uz_s1) * PW'(vy_s1);
		nya_s2 <= PW'(uz_s1) * PW'(vx_s1);
		nyb_s2 <= PW'(ux_s1) * PW'(vz_s1);
		nza_s2 <= NZPW'(ux_s1) * NZPW'(vy_s1);
		nzb_s2 <= NZPW'(uy_s1) * NZPW'(vx_s1);
		for (int i = 0; i < 3; i++) begin
			dypx_s2[i] <= EPW'(dy_s1[i]) * EPW'(px[i]);
			dxpy_s2[i] <= EPW'(dx_s1[i]) * EPW'(py[i]);
			dxys_s2[i] <= EPW'(dx_s1[i]) * EPW'(ys_s1);
			dyxs_s2[i] <= EPW'(dy_s1[i]) * EPW'(xs_s1);
		end

		nx_s3 <= NXW'(nxa_s2) - NXW'(nxb_s2);
		ny_s3 <= NXW'(nya_s2) - NXW'(nyb_s2);
		nz_s3 <= NZW'(nza_s2) - NZW'(nzb_s2);
		for (int i = 0; i < 3; i++) begin
			e0_s3[i] <= EW'(dypx_s2[i]) - EW'(dxpy_s2[i]) + EW'(dxys_s2[i])
				- EW'(dyxs_s2[i]) + $signed({{(EW-1){1'b0}}, bias_s1[i]});
		end

		pz_s4  <= NW'(item.az) * NW'(nz_s3);
		pnx_s4 <= NW'(nx_s3) * NW'(xoff_s1);
		pny_s4 <= NW'(ny_s3) * NW'(yoff_s1);

		num_s5 <= pz_s4 - pnx_s4 - pny_s4;

		num_s6   <= nz_s3[NZW-1] ? -num_s5 : num_s5;
		ndx_s6   <= nz_s3[NZW-1] ? NW'(nx_s3) : -NW'(nx_s3);
		ndy_s6   <= nz_s3[NZW-1] ? NW'(ny_s3) : -NW'(ny_s3);
		nzp_s6   <= nz_s3[NZW-1] ? RW'(-nz_s3) : RW'(nz_s3);
		empty_s6 <= empty_s1 || (nz_s3 == '0);
	end

	// floor division of num0, x step and y step by the positive normal z
	assign dsel = (state_q == ST_DIV) ? sel_q + 2'd1 : 2'd0;

	always_comb begin
		case (dsel)
			2'd0:    dval = num_s6;
			2'd1:    dval = ndx_s6;
			default: dval = ndy_s6;
		endcase
		dabs = dval[NW-1] ? -dval : dval;
		case (sel_q)
			2'd0:    cval = num_s6;
			2'd1:    cval = ndx_s6;
			default: cval = ndy_s6;
		endcase
		cneg  = cval[NW-1];
		q_fix = div_quo;
		r_fix = div_rem;
		if (cneg) begin
			if (div_rem != '0) begin
				q_fix = ~div_quo;
				r_fix = nzp_s6 - div_rem;
			end else begin
				q_fix = -div_quo;
			end
		end
	end

	assign div_start = ((state_q == ST_PIPE) && (cnt_q == PIPE_LAT))
		|| ((state_q == ST_DIV) && div_done && (sel_q != 2'd2));

	thr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dabs),
		.divisor  (nzp_s6),
		.done     (div_done),
		.quo_lo   (div_quo),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			sel_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_PIPE;
						cnt_q   <= '0;
					end
				end
				ST_PIPE: begin
					if (cnt_q == PIPE_LAT) begin
						state_q <= ST_DIV;
						sel_q   <= 2'd0;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						if (sel_q == 2'd2) begin
							state_q <= ST_IDLE;
						end else begin
							sel_q <= sel_q + 2'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DIV) && div_done) begin
			q_q[sel_q] <= q_fix;
			r_q[sel_q] <= r_fix;
		end
	end

	assign done = (state_q == ST_DIV) && div_done && (sel_q == 2'd2);

	always_comb begin
		cfg.empty = empty_s6;
		cfg.xs    = xs_s1[PXW-1:0];
		cfg.xe    = xe_s1;
		cfg.ys    = ys_s1[PXW-1:0];
		cfg.ye    = ye_s1;
		for (int i = 0; i < 3; i++) begin
			cfg.e0[i]  = e0_s3[i];
			cfg.edx[i] = dx_s1[i];
			cfg.edy[i] = dy_s1[i];
		end
		cfg.num0 = num_s6;
		cfg.ndx  = ndx_s6;
		cfg.ndy  = ndy_s6;
		cfg.nzp  = nzp_s6;
		cfg.q[0] = q_q[0];
		cfg.q[1] = q_q[1];
		cfg.q[2] = (sel_q == 2'd2 && div_done) ? q_fix : q_q[2];
		cfg.r[0] = r_q[0];
		cfg.r[1] = r_q[1];
		cfg.r[2] = (sel_q == 2'd2 && div_done) ? r_fix : r_q[2];
	end

endmodule

[design/thr_store.sv]
// ----------------------------------------------------------------------------
// thr_store
// Height map memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module thr_store #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);
	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/triangle_height_rasterizer.sv]
// ----------------------------------------------------------------------------
// triangle_height_rasterizer
// Half-space triangle rasterizer writing plane heights into a byte map.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_stall/item) takes draw, read and clear
//   transactions; result channel (result_valid/result_stall/result) returns
//   exactly one result per item. cfg channel (cfg_valid/cfg_ready) sets the
//   width and height in use; write it only while the block is idle.
//   Draw: setup (pipeline plus three passes of the shared divider), then
//   one bounding-box pixel per cycle. Read: through the registered memory
//   port, unless the position lies outside the map in use. Clear: one
//   entry written per cycle over all MAX_WIDTH * MAX_HEIGHT entries. Other
//   kinds go straight to the result.
//   One item is processed at a time; the next is taken once the current
//   result sits in the output register, even while the receiver stalls.
//   A stalled result holds until taken.
//   After reset the map is zeroed by the same sweep with item_stall high;
//   cfg writes are still taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "triangle_height_rasterizer_macros.svh"

module triangle_height_rasterizer #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  thr_pkg::item_t               item,
	output logic                         result_valid,
	input  logic                         result_stall,
	output thr_pkg::result_t             result,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [thr_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [thr_pkg::CFG_DW-1:0]   cfg_data
);
	import thr_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [2:0] S_CLR   = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_SETUP = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_READ  = 3'd4;
	localparam logic [2:0] S_RDW   = 3'd5;
	localparam logic [2:0] S_PUSH  = 3'd6;

	logic [2:0]        state_q;
	logic [PXW-1:0]    width_q, height_q;
	logic [PXW-1:0]    w_used, h_used;
	item_t             item_q;
	logic [AW-1:0]     clr_q;
	logic              clr_res_q;
	result_t           res_q;
	result_t           result_q;
	logic              result_valid_q;

	logic              accept;
	logic              setup_done;
	scan_cfg_t         cfg;

	logic [PXW-1:0]    x_q, y_q;
	logic [AW-1:0]     base_q;
	logic signed [EW-1:0] e_q [3];
	logic signed [EW-1:0] erow_q [3];
	logic signed [EW-1:0] e_nx [3];
	logic signed [EW-1:0] e_ny [3];
	logic [NW-1:0]     num_q, numrow_q;
	logic [7:0]        q_q, qrow_q;
	logic [RW-1:0]     r_q, rrow_q;
	logic [CNTW-1:0]   cnt_q;
	logic [8+RW-1:0]   qr_nx, qr_ny;
	logic [NW-1:0]     numrow_ny;
	logic              keep;
	logic              last_x, last_y;
	logic [CNTW-1:0]   cnt_nx;

	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [7:0]        mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [7:0]        mem_rdata;
	logic              rd_outside;
	logic              slot_free;

	function automatic logic [8+RW-1:0] qr_add(
		input logic [7:0]    q,
		input logic [RW-1:0] r,
		input logic [7:0]    dq,
		input logic [RW-1:0] dr,
		input logic [RW-1:0] nz
	);
		logic [RW:0] s;
		logic [RW:0] t;
		s = {1'b0, r} + {1'b0, dr};
		t = s - {1'b0, nz};
		if (!t[RW]) begin
			return {q + dq + 8'd1, t[RW-1:0]};
		end
		return {q + dq, s[RW-1:0]};
	endfunction

	assign w_used = (int'(width_q) > MAX_WIDTH) ? PXW'(MAX_WIDTH) : width_q;
	assign h_used = (int'(height_q) > MAX_HEIGHT) ? PXW'(MAX_HEIGHT) : height_q;

	assign item_stall   = (state_q != S_IDLE);
	assign accept       = item_valid && !item_stall;
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign slot_free    = !result_valid_q || !result_stall;

	thr_setup u_setup (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && (item.kind == KIND_DRAW)),
		.item   (item_q),
		.w_used (w_used),
		.h_used (h_used),
		.done   (setup_done),
		.cfg    (cfg)
	);

	// scan datapath
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			e_nx[i] = e_q[i] - EW'($signed(cfg.edy[i]));
			e_ny[i] = erow_q[i] + EW'($signed(cfg.edx[i]));
		end
		keep      = (e_q[0] > 0) && (e_q[1] > 0) && (e_q[2] > 0);
		last_x    = (x_q + PXW'(1)) >= cfg.xe;
		last_y    = (y_q + PXW'(1)) >= cfg.ye;
		qr_nx     = qr_add(q_q, r_q, cfg.q[1], cfg.r[1], cfg.nzp);
		qr_ny     = qr_add(qrow_q, rrow_q, cfg.q[2], cfg.r[2], cfg.nzp);
		numrow_ny = numrow_q + cfg.ndy;
		cnt_nx    = cnt_q + {{(CNTW-1){1'b0}}, keep};
	end

	assign rd_outside = ({1'b0, item_q.read_col} >= w_used)
		|| ({1'b0, item_q.read_row} >= h_used);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = base_q + AW'(x_q);
		mem_wdata = q_q + {7'b0, (r_q != '0) && num_q[NW-1]};
		if (state_q == S_CLR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = 8'd0;
		end else if (state_q == S_SCAN) begin
			mem_we = keep;
		end
		mem_re    = (state_q == S_READ) && !rd_outside;
		mem_raddr = AW'(17'(item_q.read_col) + 17'(w_used) * 17'(item_q.read_row));
	end

	thr_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLR;
			clr_q          <= '0;
			clr_res_q      <= 1'b0;
			width_q        <= 9'd256;
			height_q       <= 9'd256;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_WIDTH:  width_q  <= cfg_data;
					REG_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end
			if ((state_q == S_PUSH) && slot_free) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					if (clr_q == AW'(DEPTH - 1)) begin
						clr_q   <= '0;
						state_q <= clr_res_q ? S_PUSH : S_IDLE;
					end else begin
						clr_q <= clr_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (accept) begin
						unique case (item.kind)
							KIND_DRAW:  state_q <= S_SETUP;
							KIND_READ:  state_q <= S_READ;
							KIND_CLEAR: begin
								state_q   <= S_CLR;
								clr_res_q <= 1'b1;
							end
							default:    state_q <= S_PUSH;
						endcase
					end
				end
				S_SETUP: begin
					if (setup_done) begin
						state_q <= cfg.empty ? S_PUSH : S_SCAN;
					end
				end
				S_SCAN: begin
					if (last_x && last_y) begin
						state_q <= S_PUSH;
					end
				end
				S_READ:  state_q <= rd_outside ? S_PUSH : S_RDW;
				S_RDW:   state_q <= S_PUSH;
				S_PUSH: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
			res_q  <= '0;
		end
		if ((state_q == S_PUSH) && slot_free) begin
			result_q <= res_q;
		end
		if (state_q == S_READ) begin
			res_q.read_outside <= rd_outside;
		end
		if (state_q == S_RDW) begin
			res_q.read_value <= mem_rdata;
		end
		if ((state_q == S_SETUP) && setup_done) begin
			x_q      <= cfg.xs;
			y_q      <= cfg.ys;
			base_q   <= AW'({9'b0, w_used} * {9'b0, cfg.ys});
			num_q    <= cfg.num0;
			numrow_q <= cfg.num0;
			q_q      <= cfg.q[0];
			qrow_q   <= cfg.q[0];
			r_q      <= cfg.r[0];
			rrow_q   <= cfg.r[0];
			cnt_q    <= '0;
			for (int i = 0; i < 3; i++) begin
				e_q[i]    <= $signed(cfg.e0[i]);
				erow_q[i] <= $signed(cfg.e0[i]);
			end
		end
		if (state_q == S_SCAN) begin
			cnt_q <= cnt_nx;
			if (!last_x) begin
				x_q   <= x_q + PXW'(1);
				num_q <= num_q + cfg.ndx;
				q_q   <= qr_nx[8+RW-1:RW];
				r_q   <= qr_nx[RW-1:0];
				for (int i = 0; i < 3; i++) begin
					e_q[i] <= e_nx[i];
				end
			end else if (!last_y) begin
				x_q      <= cfg.xs;
				y_q      <= y_q + PXW'(1);
				base_q   <= base_q + AW'(w_used);
				num_q    <= numrow_ny;
				numrow_q <= numrow_ny;
				q_q      <= qr_ny[8+RW-1:RW];
				qrow_q   <= qr_ny[8+RW-1:RW];
				r_q      <= qr_ny[RW-1:0];
				rrow_q   <= qr_ny[RW-1:0];
				for (int i = 0; i < 3; i++) begin
					e_q[i]    <= e_ny[i];
					erow_q[i] <= e_ny[i];
				end
			end else begin
				res_q.pixels_written <= cnt_nx;
			end
		end
	end

	`THR_ASSERT_IMP(a_clr_blocks_items, state_q == S_CLR, item_stall)
	`THR_ASSERT_IMP(a_scan_in_box, state_q == S_SCAN, (x_q < cfg.xe) && (y_q < cfg.ye))
	`THR_ASSERT_IMP(a_rem_below_nz, state_q == S_SCAN, r_q < cfg.nzp)
	`THR_ASSERT_IMP(a_outside_zero, result_valid_q && result_q.read_outside, result_q.read_value == 8'd0)

endmodule
